@@ design/dpdi_preamble_correlator_unit_assert.svh @@
// Assertion macros for the preamble correlator checker.
// Included by dpc_checker.sv; no other dependencies.
`ifndef DPDI_PREAMBLE_CORRELATOR_UNIT_ASSERT_SVH
`define DPDI_PREAMBLE_CORRELATOR_UNIT_ASSERT_SVH

// hold a stalled word and its valid
`define DPC_ASSERT_HOLD(lbl, clk, rst_n, vld, rdy, data) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) \
		(vld && !rdy) |=> (vld && $stable(data))) else $error("stalled word changed");

// same-cycle implication
`define DPC_ASSERT_IMPL(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) \
		(a) |-> (b)) else $error("implication failed");

// next-cycle implication
`define DPC_ASSERT_NEXT(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) \
		(a) |=> (b)) else $error("next-cycle implication failed");

`endif

@@ design/dpc_pkg.sv @@
// Types and constants shared by the preamble correlator files.
// No dependencies.
package dpc_pkg;

	localparam int COEF_W      = 16;
	localparam int FIELD_W     = 16;
	localparam int ACC_W       = 32;
	localparam int PROD_W      = 64;
	localparam int POW_W       = 48;
	localparam int IDX_W       = 5;
	localparam int POS_W       = 2;
	localparam int TAP_SHIFT   = 14;
	localparam int DIFF_SHIFT  = 11;
	localparam int POWER_SHIFT = 16;

	typedef enum logic {
		ACT_SAMPLE = 1'b0,
		ACT_COEF   = 1'b1
	} action_t;

	typedef struct packed {
		action_t                    action;
		logic signed [FIELD_W-1:0]  sample_re;
		logic signed [FIELD_W-1:0]  sample_im;
		logic        [IDX_W-1:0]    coef_index;
		logic signed [COEF_W-1:0]   coef_re;
		logic signed [COEF_W-1:0]   coef_im;
	} in_word_t;

	typedef struct packed {
		logic                       detected;
		logic        [POW_W-1:0]    peak_power;
		logic signed [ACC_W-1:0]    peak_re;
		logic signed [ACC_W-1:0]    peak_im;
		logic        [POS_W-1:0]    peak_position;
	} out_word_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SETTLE,
		ST_MUL,
		ST_ACC,
		ST_MAN,
		ST_SQR,
		ST_POW,
		ST_THR,
		ST_SEARCH,
		ST_DONE,
		ST_OUT
	} state_t;

endpackage

@@ design/dpc_cell.sv @@
// One tap cell: a symbol's worth of delay line, one preamble coefficient,
// the tap product and the running group sum. Depends on dpc_pkg.
module dpc_cell import dpc_pkg::*; #(
	parameter int SPS   = 4,
	parameter int SW    = 16,
	parameter bit FIRST = 1'b0
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      shift_en,
	input  logic signed [SW-1:0]      smp_re_in,
	input  logic signed [SW-1:0]      smp_im_in,
	output logic signed [SW-1:0]      tap_re,
	output logic signed [SW-1:0]      tap_im,
	input  logic                      coef_we,
	input  logic signed [COEF_W-1:0]  coef_re,
	input  logic signed [COEF_W-1:0]  coef_im,
	input  logic signed [ACC_W-1:0]   acc_re_in,
	input  logic signed [ACC_W-1:0]   acc_im_in,
	output logic signed [ACC_W-1:0]   acc_re,
	output logic signed [ACC_W-1:0]   acc_im
);

	localparam int PW = COEF_W + SW + 1;

	logic signed [SW-1:0]     line_re_q [SPS];
	logic signed [SW-1:0]     line_im_q [SPS];
	logic signed [COEF_W-1:0] coef_re_q, coef_im_q;
	logic signed [ACC_W-1:0]  prod_re_q, prod_im_q;
	logic signed [ACC_W-1:0]  acc_re_q, acc_im_q;
	logic signed [PW-1:0]     pr, pi, prs, pis;
	logic signed [ACC_W-1:0]  base_re, base_im;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < SPS; j++) begin
				line_re_q[j] <= '0;
				line_im_q[j] <= '0;
			end
		end else if (shift_en) begin
			line_re_q[0] <= smp_re_in;
			line_im_q[0] <= smp_im_in;
			for (int j = 1; j < SPS; j++) begin
				line_re_q[j] <= line_re_q[j-1];
				line_im_q[j] <= line_im_q[j-1];
			end
		end
	end

	assign tap_re = line_re_q[SPS-1];
	assign tap_im = line_im_q[SPS-1];

	always_ff @(posedge clk) begin
		if (coef_we) begin
			coef_re_q <= coef_re;
			coef_im_q <= coef_im;
		end
	end

	always_comb begin
		pr  = PW'(coef_re_q) * PW'(tap_re) - PW'(coef_im_q) * PW'(tap_im);
		pi  = PW'(coef_re_q) * PW'(tap_im) + PW'(coef_im_q) * PW'(tap_re);
		prs = pr >>> TAP_SHIFT;
		pis = pi >>> TAP_SHIFT;
	end

	assign base_re = FIRST ? '0 : acc_re_in;
	assign base_im = FIRST ? '0 : acc_im_in;

	always_ff @(posedge clk) begin
		prod_re_q <= ACC_W'(prs);
		prod_im_q <= ACC_W'(pis);
		acc_re_q  <= base_re + prod_re_q;
		acc_im_q  <= base_im + prod_im_q;
	end

	assign acc_re = acc_re_q;
	assign acc_im = acc_im_q;

endmodule

@@ design/dpdi_preamble_correlator_unit.sv @@
// Top level of the preamble correlator: tap cell row, differential step,
// power history, peak search and handshakes. Depends on dpc_pkg, dpc_cell.
//
//  channel | dir | payload    | handshake
//  in      | in  | in_word_t  | in_valid / in_ready
//  out     | out | out_word_t | out_valid / out_ready
//  cfg     | in  | 48b thresh | cfg_valid / cfg_ready
//
// A sample word lets the group sums ripple through the cell row, then one
// complex multiplier serves each group in turn; when a burst is detected the
// peak search reads one history entry a cycle. A coefficient word goes
// straight to the output state. Reset clears the delay line and histories
// at once. A stalled output holds one result; the next word is taken while
// it waits.
module dpdi_preamble_correlator_unit import dpc_pkg::*; #(
	parameter int SAMPLES_PER_SYMBOL = 4,
	parameter int GROUP_LEN          = 8,
	parameter int GROUP_COUNT        = 4,
	parameter int PREAMBLE_LEN       = 32,
	parameter int SAMPLE_WIDTH       = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  in_word_t         in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output out_word_t        out_data,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [POW_W-1:0] cfg_data
);

	localparam int SPS   = SAMPLES_PER_SYMBOL;
	localparam int M     = GROUP_LEN;
	localparam int L     = GROUP_COUNT;
	localparam int P     = PREAMBLE_LEN;
	localparam int SW    = SAMPLE_WIDTH;
	localparam int RAW_W = (SW > FIELD_W) ? SW : FIELD_W;
	localparam int CW    = $clog2(M + 2);
	localparam int GW    = (L > 1) ? $clog2(L) : 1;
	localparam int KW    = $clog2(SPS);

	state_t state_q, state_d;

	logic accept, line_shift, coef_load, out_free, res_load;

	logic [POW_W-1:0]        thr_q;
	logic [CW-1:0]           cnt_q;
	logic [GW-1:0]           grp_q;
	logic [KW-1:0]           k_q, best_idx_q;
	logic                    out_valid_q;
	out_word_t               out_data_q, res_q;

	logic [RAW_W-1:0]        raw_re, raw_im;
	logic signed [SW-1:0]    smp_re, smp_im;

	logic signed [SW-1:0]    tap_re_w [P];
	logic signed [SW-1:0]    tap_im_w [P];
	logic signed [ACC_W-1:0] acc_re_w [P];
	logic signed [ACC_W-1:0] acc_im_w [P];
	logic signed [ACC_W-1:0] grp_re   [L];
	logic signed [ACC_W-1:0] grp_im   [L];

	logic signed [ACC_W-1:0]  prev_re_q, prev_im_q, zl_re_q, zl_im_q;
	logic signed [PROD_W-1:0] m_rr_s1, m_ii_s1, m_ir_s1, m_ri_s1;
	logic signed [PROD_W-1:0] dr, di, drs, dis;
	logic signed [ACC_W-1:0]  x_re, x_im;

	logic signed [ACC_W-1:0]  diff_re_q [SPS];
	logic signed [ACC_W-1:0]  diff_im_q [SPS];
	logic signed [ACC_W-1:0]  sum_re_q  [SPS];
	logic signed [ACC_W-1:0]  sum_im_q  [SPS];
	logic [POW_W-1:0]         pow_q     [SPS];
	logic signed [ACC_W-1:0]  ms_re_q, ms_im_q;
	logic signed [PROD_W-1:0] sq_re_s1, sq_im_s1;
	logic [PROD_W-1:0]        pow_full;
	logic [POW_W-1:0]         best_pow_q;
	logic signed [ACC_W-1:0]  best_re_q, best_im_q;

	assign raw_re = RAW_W'($unsigned(in_data.sample_re));
	assign raw_im = RAW_W'($unsigned(in_data.sample_im));
	assign smp_re = $signed(raw_re[SW-1:0]);
	assign smp_im = $signed(raw_im[SW-1:0]);

	for (genvar t = 0; t < P; t++) begin : g_cell
		logic signed [SW-1:0]    s_re, s_im;
		logic signed [ACC_W-1:0] a_re, a_im;
		logic                    we;

		if (t == P - 1) begin : g_head
			assign s_re = smp_re;
			assign s_im = smp_im;
		end else begin : g_body
			assign s_re = tap_re_w[t+1];
			assign s_im = tap_im_w[t+1];
		end

		if (t == 0) begin : g_first
			assign a_re = '0;
			assign a_im = '0;
		end else begin : g_rest
			assign a_re = acc_re_w[t-1];
			assign a_im = acc_im_w[t-1];
		end

		assign we = coef_load && (int'(in_data.coef_index) == t);

		dpc_cell #(
			.SPS   (SPS),
			.SW    (SW),
			.FIRST ((t % M) == 0)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.shift_en  (line_shift),
			.smp_re_in (s_re),
			.smp_im_in (s_im),
			.tap_re    (tap_re_w[t]),
			.tap_im    (tap_im_w[t]),
			.coef_we   (we),
			.coef_re   (in_data.coef_re),
			.coef_im   (in_data.coef_im),
			.acc_re_in (a_re),
			.acc_im_in (a_im),
			.acc_re    (acc_re_w[t]),
			.acc_im    (acc_im_w[t])
		);
	end

	for (genvar i = 0; i < L; i++) begin : g_grp
		localparam int END = ((i + 1) * M - 1 < P - 1) ? (i + 1) * M - 1 : P - 1;
		if (i * M < P) begin : g_live
			assign grp_re[i] = acc_re_w[END];
			assign grp_im[i] = acc_im_w[END];
		end else begin : g_void
			assign grp_re[i] = '0;
			assign grp_im[i] = '0;
		end
	end

	assign x_re = grp_re[grp_q];
	assign x_im = grp_im[grp_q];

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = (in_data.action == ACT_COEF) ? ST_OUT : ST_SETTLE;
				end
			end
			ST_SETTLE: begin
				if (cnt_q == CW'(M)) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL:    state_d = ST_ACC;
			ST_ACC: begin
				if (grp_q == GW'(L - 1)) begin
					state_d = ST_MAN;
				end else begin
					state_d = ST_MUL;
				end
			end
			ST_MAN:    state_d = ST_SQR;
			ST_SQR:    state_d = ST_POW;
			ST_POW:    state_d = ST_THR;
			ST_THR:    state_d = (pow_q[SPS-1] > thr_q) ? ST_SEARCH : ST_OUT;
			ST_SEARCH: begin
				if (k_q == KW'(SPS - 1)) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE:   state_d = ST_OUT;
			ST_OUT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_ready   = (state_q == ST_IDLE);
		accept     = in_valid && in_ready;
		line_shift = accept && (in_data.action == ACT_SAMPLE);
		coef_load  = accept && (in_data.action == ACT_COEF);
		out_free   = !out_valid_q || out_ready;
		res_load   = (state_q == ST_OUT) && out_free;
	end

	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_comb begin
		dr       = m_rr_s1 + m_ii_s1;
		di       = m_ir_s1 - m_ri_s1;
		drs      = dr >>> DIFF_SHIFT;
		dis      = di >>> DIFF_SHIFT;
		pow_full = $unsigned(sq_re_s1) + $unsigned(sq_im_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			thr_q       <= '0;
			cnt_q       <= '0;
			grp_q       <= '0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
			for (int j = 0; j < SPS; j++) begin
				diff_re_q[j] <= '0;
				diff_im_q[j] <= '0;
				sum_re_q[j]  <= '0;
				sum_im_q[j]  <= '0;
				pow_q[j]     <= '0;
			end
		end else begin
			state_q <= state_d;
			if (cfg_valid) begin
				thr_q <= cfg_data;
			end
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					grp_q <= '0;
				end
				ST_SETTLE: cnt_q <= cnt_q + CW'(1);
				ST_ACC:    grp_q <= grp_q + GW'(1);
				ST_MAN: begin
					diff_re_q[0] <= zl_re_q;
					diff_im_q[0] <= zl_im_q;
					for (int j = 1; j < SPS; j++) begin
						diff_re_q[j] <= diff_re_q[j-1];
						diff_im_q[j] <= diff_im_q[j-1];
					end
				end
				ST_POW: begin
					pow_q[0]    <= pow_full[PROD_W-1:POWER_SHIFT];
					sum_re_q[0] <= ms_re_q;
					sum_im_q[0] <= ms_im_q;
					for (int j = 1; j < SPS; j++) begin
						pow_q[j]    <= pow_q[j-1];
						sum_re_q[j] <= sum_re_q[j-1];
						sum_im_q[j] <= sum_im_q[j-1];
					end
				end
				ST_THR:    k_q <= KW'(1);
				ST_SEARCH: k_q <= k_q + KW'(1);
				ST_DONE: begin
					for (int j = 0; j < SPS; j++) begin
						sum_re_q[j] <= '0;
						sum_im_q[j] <= '0;
						pow_q[j]    <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (coef_load) begin
			res_q <= '0;
		end
		if (line_shift) begin
			prev_re_q <= '0;
			prev_im_q <= '0;
			zl_re_q   <= '0;
			zl_im_q   <= '0;
		end
		if (res_load) begin
			out_data_q <= res_q;
		end
		unique case (state_q)
			ST_MUL: begin
				m_rr_s1 <= x_re * prev_re_q;
				m_ii_s1 <= x_im * prev_im_q;
				m_ir_s1 <= x_im * prev_re_q;
				m_ri_s1 <= x_re * prev_im_q;
			end
			ST_ACC: begin
				zl_re_q   <= zl_re_q + ACC_W'(drs);
				zl_im_q   <= zl_im_q + ACC_W'(dis);
				prev_re_q <= x_re;
				prev_im_q <= x_im;
			end
			ST_MAN: begin
				ms_re_q <= zl_re_q + diff_re_q[SPS/2-1];
				ms_im_q <= zl_im_q + diff_im_q[SPS/2-1];
			end
			ST_SQR: begin
				sq_re_s1 <= ms_re_q * ms_re_q;
				sq_im_s1 <= ms_im_q * ms_im_q;
			end
			ST_THR: begin
				best_pow_q <= pow_q[0];
				best_re_q  <= sum_re_q[0];
				best_im_q  <= sum_im_q[0];
				best_idx_q <= '0;
				if (!(pow_q[SPS-1] > thr_q)) begin
					res_q <= '0;
				end
			end
			ST_SEARCH: begin
				if (pow_q[k_q] > best_pow_q) begin
					best_pow_q <= pow_q[k_q];
					best_re_q  <= sum_re_q[k_q];
					best_im_q  <= sum_im_q[k_q];
					best_idx_q <= k_q;
				end
			end
			ST_DONE: begin
				res_q.detected      <= 1'b1;
				res_q.peak_power    <= best_pow_q;
				res_q.peak_re       <= best_re_q;
				res_q.peak_im       <= best_im_q;
				res_q.peak_position <= POS_W'(best_idx_q);
			end
			default: ;
		endcase
	end

endmodule

@@ design/dpc_checker.sv @@
// Port-level checks for the preamble correlator, bound to the top level.
// Depends on dpc_pkg and dpdi_preamble_correlator_unit_assert.svh.
`include "dpdi_preamble_correlator_unit_assert.svh"

module dpc_checker import dpc_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input in_word_t         in_data,
	input logic             out_valid,
	input logic             out_ready,
	input out_word_t        out_data,
	input logic             cfg_valid,
	input logic             cfg_ready,
	input logic [POW_W-1:0] cfg_data
);

	`DPC_ASSERT_HOLD(a_out_hold, clk, arst_n, out_valid, out_ready, out_data)
	`DPC_ASSERT_IMPL(a_quiet_zero, clk, arst_n, out_valid && !out_data.detected, out_data.peak_power == '0 && out_data.peak_position == '0 && out_data.peak_re == '0)
	`DPC_ASSERT_IMPL(a_peak_nonzero, clk, arst_n, out_valid && out_data.detected, out_data.peak_power != '0)
	`DPC_ASSERT_NEXT(a_one_at_a_time, clk, arst_n, in_valid && in_ready, !in_ready)

endmodule

bind dpdi_preamble_correlator_unit dpc_checker u_dpc_checker (.*);
